// File: sv/frdr_pkg.sv
// frdr_pkg: shared constants, tap table and control types of the resampler
// depends on nothing; used by frdr_mac, the top level, the output checker and the testbench
package frdr_pkg;

    // window length and default sample width
    localparam int TAPS        = 23;
    localparam int SAMPLE_BITS = 16;

    // tap coefficients and product shift
    localparam int COEF_W      = 16;
    localparam int ROUND_SHIFT = 15;

    // window position, Q12.16, and sample counter
    localparam int POS_W  = 28;
    localparam int FRAC_W = 16;
    localparam int SSN_W  = 12;

    // rate ratio register, unsigned Q5.16
    localparam int RATIO_W = 21;
    localparam logic [RATIO_W-1:0] RATIO_MIN   = 21'd65536;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 21'd1048576;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 21'd196608;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_RATIO     = 2'd1;

    // counter over the taps, one extra count marks the end of a pass
    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int IDX_W = $clog2(TAPS);

    // normalized sinc taps, cutoff one third, sum 32768; entry 0 meets the oldest sample
    localparam logic signed [COEF_W-1:0] TAP_COEF [TAPS] = '{
        -16'sd860,  -16'sd946,  16'sd0,     16'sd1183,  16'sd1352,  16'sd0,
        -16'sd1892, -16'sd2366, 16'sd0,     16'sd4731,  16'sd9462,  16'sd11440,
        16'sd9462,  16'sd4731,  16'sd0,     -16'sd2366, -16'sd1892, 16'sd0,
        16'sd1352,  16'sd1183,  16'sd0,     -16'sd946,  -16'sd860
    };

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic step;
    } mac_ctrl_t;

endpackage

// File: sv/frdr_cell.sv
// frdr_cell: one history cell of the sample ring
// depends on nothing but its width parameter
module frdr_cell #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         clear,
    input  logic         shift,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] value_reg;
    logic [W-1:0] value_next;

    // clear wins over a shift from the neighbor
    always_comb
    begin
        value_next = value_reg;
        if (clear)
        begin
            value_next = '0;
        end
        else if (shift)
        begin
            value_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign q = value_reg;

endmodule

// File: sv/frdr_mac.sv
// frdr_mac: shared multiply-accumulate over the taps, with rounding and saturation
// depends on frdr_pkg for the tap table and the control struct
module frdr_mac #(
    parameter int SAMPLE_BITS = frdr_pkg::SAMPLE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  frdr_pkg::mac_ctrl_t            ctrl,
    input  logic [frdr_pkg::IDX_W-1:0]     coef_idx,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    output logic signed [SAMPLE_BITS-1:0]  result
);

    localparam int PROD_W = SAMPLE_BITS + frdr_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(frdr_pkg::TAPS);
    localparam int Q_W    = ACC_W + 1 - frdr_pkg::ROUND_SHIFT;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W:0]    rounded;
    logic signed [Q_W-1:0]    scaled;
    logic signed [Q_W-1:0]    sat_hi;
    logic signed [Q_W-1:0]    sat_lo;

    // product stage, registered before the add
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(sample) * PROD_W'(frdr_pkg::TAP_COEF[coef_idx]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.step;
        end
    end

    // accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // round to nearest, ties up, then saturate
    assign rounded = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(1 << (frdr_pkg::ROUND_SHIFT - 1));
    assign scaled  = Q_W'(rounded >>> frdr_pkg::ROUND_SHIFT);
    assign sat_hi  = {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    assign sat_lo  = ~sat_hi;

    always_comb
    begin
        if (scaled > sat_hi)
        begin
            result = sat_hi[SAMPLE_BITS-1:0];
        end
        else if (scaled < sat_lo)
        begin
            result = sat_lo[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = scaled[SAMPLE_BITS-1:0];
        end
    end

endmodule

// File: sv/fractional_decimating_fir_resampler_core.sv
// fractional_decimating_fir_resampler_core: top level of the fractional sinc resampler
// depends on frdr_pkg, frdr_cell and frdr_mac
//
// Usage
// - input channel in_valid / in_stall / in_sample carries one mono sample per word;
//   output channel out_valid / out_stall / out_sample carries one filtered word
// - each input word gives zero or one output word; output windows start at
//   round(k * rate_ratio) input samples, rate_ratio unsigned Q5.16 in 1.0 .. 16.0
// - a word that completes no window is taken and in_stall stays low
// - a word that completes a window rotates the 23-cell history ring once past a single
//   shared multiplier: a multiply step for each tap, then a drain step and a rounding step;
//   in_stall stays high until the rounding step hands the result to the output register
// - the output register holds a finished word while the next input word is taken;
//   if out_stall keeps it full, the next finished word waits in the rounding step
// - capture_enable low: input words are taken and dropped, history and phase cleared;
//   writing 0 clears them at once; configuration must be written only while idle (the block does not enforce this)
// - reset clears history, phase, enable and the output valid flag; ratio resets to 3.0
module fractional_decimating_fir_resampler_core #(
    parameter int SAMPLE_BITS = frdr_pkg::SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [frdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [frdr_pkg::RATIO_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       in_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       out_sample
);

    localparam int TAPS   = frdr_pkg::TAPS;
    localparam int POS_W  = frdr_pkg::POS_W;
    localparam int FRAC_W = frdr_pkg::FRAC_W;
    localparam int SSN_W  = frdr_pkg::SSN_W;
    localparam int INT_W  = POS_W + 1 - FRAC_W;
    localparam int CNT_W  = frdr_pkg::CNT_W;
    localparam int IDX_W  = frdr_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [CNT_W-1:0]                 cnt_next;
    logic                             enable_reg;
    logic [frdr_pkg::RATIO_W-1:0]     ratio_reg;
    logic [POS_W-1:0]                 wp_reg;
    logic [POS_W-1:0]                 wp_next;
    logic [SSN_W-1:0]                 ssn_reg;
    logic [SSN_W-1:0]                 ssn_next;
    logic [POS_W:0]                   pos_sum_reg;
    logic                             out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]    out_sample_reg;

    logic                             in_accept;
    logic                             cfg_clear;
    logic                             ring_clear;
    logic                             ring_shift;
    logic                             rotating;
    logic [SSN_W-1:0]                 ssn_inc;
    logic [POS_W:0]                   start_sum;
    logic [INT_W-1:0]                 start_idx;
    logic                             hit;
    logic [INT_W-1:0]                 rebase_n;
    logic [INT_W-1:0]                 pos_int;
    logic                             out_free;
    logic [frdr_pkg::RATIO_W-1:0]     ratio_clamped;
    logic signed [SAMPLE_BITS-1:0]    mac_result;
    frdr_pkg::mac_ctrl_t              mac_ctrl;
    logic [SAMPLE_BITS-1:0]           cell_q [TAPS];
    logic [SAMPLE_BITS-1:0]           cell_d [TAPS];

    // handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign rotating  = (state_reg == S_MAC);

    // window check: does the new sample close the current window
    assign ssn_inc   = ssn_reg + SSN_W'(1);
    assign start_sum = {1'b0, wp_reg} + (POS_W+1)'(1 << (FRAC_W - 1));
    assign start_idx = start_sum[POS_W:FRAC_W];
    assign hit       = ((INT_W+1)'(ssn_inc) == (INT_W+1)'(start_idx) + (INT_W+1)'(TAPS));

    // rebase amount: the smaller of the position's integer part and the count
    assign pos_int  = pos_sum_reg[POS_W:FRAC_W];
    assign rebase_n = (pos_int > INT_W'(ssn_reg)) ? INT_W'(ssn_reg) : pos_int;

    // ratio clamp on write
    always_comb
    begin
        if (cfg_data < frdr_pkg::RATIO_MIN)
        begin
            ratio_clamped = frdr_pkg::RATIO_MIN;
        end
        else if (cfg_data > frdr_pkg::RATIO_MAX)
        begin
            ratio_clamped = frdr_pkg::RATIO_MAX;
        end
        else
        begin
            ratio_clamped = cfg_data;
        end
    end

    assign cfg_clear = cfg_write && (cfg_index == frdr_pkg::REG_CAPTURE_ENABLE) && !cfg_data[0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            ratio_reg  <= frdr_pkg::RATIO_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                frdr_pkg::REG_CAPTURE_ENABLE: enable_reg <= cfg_data[0];
                frdr_pkg::REG_RATE_RATIO:     ratio_reg  <= ratio_clamped;
                default:                      ;
            endcase
        end
    end

    // sample ring: shift in on enabled accept, else clear; rotate through the multiplier during a pass
    assign ring_clear = cfg_clear || (in_accept && !enable_reg);
    assign ring_shift = (in_accept && enable_reg) || rotating;

    always_comb
    begin
        cell_d[0] = rotating ? cell_q[TAPS-1] : in_sample;
        for (int i = 1; i < TAPS; i++)
        begin
            cell_d[i] = cell_q[i-1];
        end
    end

    for (genvar g = 0; g < TAPS; g++)
    begin : g_cell
        frdr_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (ring_clear),
            .shift (ring_shift),
            .d     (cell_d[g]),
            .q     (cell_q[g])
        );
    end

    // shared multiply-accumulate
    assign mac_ctrl.clear = in_accept;
    assign mac_ctrl.step  = rotating;

    frdr_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .coef_idx (cnt_reg[IDX_W-1:0]),
        .sample   (cell_q[TAPS-1]),
        .result   (mac_result)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && enable_reg && hit)
                begin
                    state_next = S_MAC;
                    cnt_next   = '0;
                end
            end
            S_MAC:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // window position and sample count
    always_comb
    begin
        wp_next  = wp_reg;
        ssn_next = ssn_reg;
        if (ring_clear)
        begin
            wp_next  = '0;
            ssn_next = '0;
        end
        else if (in_accept)
        begin
            ssn_next = ssn_inc;
        end
        else if (rotating && (cnt_reg == CNT_W'(1)))
        begin
            wp_next  = POS_W'({pos_int - rebase_n, pos_sum_reg[FRAC_W-1:0]});
            ssn_next = ssn_reg - SSN_W'(rebase_n);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            ssn_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            ssn_reg <= ssn_next;
        end
    end

    // advance by the ratio in the first cycle of a pass
    always_ff @(posedge clk)
    begin
        if (rotating && (cnt_reg == '0))
        begin
            pos_sum_reg <= {1'b0, wp_reg} + (POS_W+1)'(ratio_reg);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_sample_reg <= mac_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    // checks
    a_disabled_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !enable_reg) |=> (ssn_reg == '0 && wp_reg == '0))
        else $error("dropped word did not clear the phase");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output word loaded outside the rounding step");

    a_drain_after_full_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (cnt_reg == CNT_W'(TAPS)))
        else $error("multiply pass ended early or late");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("finished word not handed to the output register");

endmodule

// File: tb/sv/frdr_output_checker.sv
// frdr_output_checker: predicts each output word of the resampler and compares it with the block
// depends on frdr_pkg for widths, register indexes and the tap table
module frdr_output_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [frdr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [frdr_pkg::RATIO_W-1:0]            cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic signed [frdr_pkg::SAMPLE_BITS-1:0] in_sample,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic signed [frdr_pkg::SAMPLE_BITS-1:0] out_sample,
    output int                                      mismatches,
    output int                                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS        = frdr_pkg::TAPS;
    localparam int SAMPLE_BITS = frdr_pkg::SAMPLE_BITS;
    localparam int RATIO_W     = frdr_pkg::RATIO_W;
    localparam int POS_W       = frdr_pkg::POS_W;
    localparam int FRAC_W      = frdr_pkg::FRAC_W;
    localparam int SSN_W       = frdr_pkg::SSN_W;
    localparam int ROUND_SHIFT = frdr_pkg::ROUND_SHIFT;

    localparam longint WORD_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam longint HALF_LSB = longint'(1) << (ROUND_SHIFT - 1);

    // shadow of the block: registers, history and window phase
    logic                          capture_on;
    logic [RATIO_W-1:0]            ratio_reg;
    logic signed [SAMPLE_BITS-1:0] history [TAPS];
    logic [POS_W-1:0]              next_window;
    logic [SSN_W-1:0]              sample_count;

    // output words still owed by the block, oldest first
    logic signed [SAMPLE_BITS-1:0] expected_words [$];
    logic signed [SAMPLE_BITS-1:0] predicted;
    int                            failures;

    assign mismatches = failures;

    function automatic void forget_stream();
        for (int i = 0; i < TAPS; i++)
            history[i] = '0;
        next_window  = '0;
        sample_count = '0;
    endfunction

    // ratio as the block uses it, held inside 1.0 .. 16.0
    function automatic logic [RATIO_W-1:0] ratio_in_use();
        if (ratio_reg < frdr_pkg::RATIO_MIN)
            return frdr_pkg::RATIO_MIN;
        if (ratio_reg > frdr_pkg::RATIO_MAX)
            return frdr_pkg::RATIO_MAX;
        return ratio_reg;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] filtered_word();
        longint acc;
        longint scaled;
        acc = 0;
        // oldest sample of the window meets tap 0
        for (int i = 0; i < TAPS; i++)
            acc += longint'(history[TAPS-1-i]) * longint'(frdr_pkg::TAP_COEF[i]);
        // halves round toward plus infinity, then clip
        scaled = (acc + HALF_LSB) >>> ROUND_SHIFT;
        if (scaled > WORD_MAX)
            scaled = WORD_MAX;
        if (scaled < WORD_MIN)
            scaled = WORD_MIN;
        return scaled[SAMPLE_BITS-1:0];
    endfunction

    function automatic void take_sample(input logic signed [SAMPLE_BITS-1:0] value);
        logic [31:0] pos_wide;
        logic [31:0] count_wide;
        logic [31:0] first_index;
        logic [31:0] advanced;
        logic [31:0] shift_by;
        logic [31:0] remaining;
        if (!capture_on)
        begin
            forget_stream();
            return;
        end
        for (int i = TAPS - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0]   = value;
        sample_count = sample_count + SSN_W'(1);
        // window starts at the rounded position
        pos_wide    = 32'(next_window);
        count_wide  = 32'(sample_count);
        first_index = (pos_wide + 32'h8000) >> FRAC_W;
        if (count_wide != first_index + 32'(TAPS))
            return;
        expected_words.push_back(filtered_word());
        // advance, then rebase position and count by the whole samples passed
        advanced = pos_wide + 32'(ratio_in_use());
        shift_by = advanced >> FRAC_W;
        if (shift_by > count_wide)
            shift_by = count_wide;
        remaining    = advanced - (shift_by << FRAC_W);
        next_window  = remaining[POS_W-1:0];
        sample_count = sample_count - shift_by[SSN_W-1:0];
    endfunction

    // output compare first, so a word can never meet its own expectation in the same cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_on = 1'b0;
            ratio_reg  = frdr_pkg::RATIO_RESET;
            forget_stream();
            expected_words.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    failures++;
                    $error("out_sample: expected no word, got %0d", out_sample);
                end
                else
                begin
                    predicted = expected_words.pop_front();
                    if (out_sample !== predicted)
                    begin
                        failures++;
                        $error("out_sample: expected %0d, got %0d", predicted, out_sample);
                    end
                end
            end

            // register writes
            if (cfg_write)
            begin
                if (cfg_index == frdr_pkg::REG_CAPTURE_ENABLE)
                begin
                    capture_on = cfg_data[0];
                    if (!capture_on)
                        forget_stream();
                end
                else if (cfg_index == frdr_pkg::REG_RATE_RATIO)
                    ratio_reg = cfg_data;
            end

            // accepted input word
            if (in_valid && !in_stall)
                take_sample(in_sample);

            outstanding <= expected_words.size();
        end
    end

endmodule

// File: tb/sv/tb_fractional_decimating_fir_resampler_core.sv
// tb_fractional_decimating_fir_resampler_core: stimulus and verdict for the resampler core
// depends on frdr_pkg, the core and frdr_output_checker, which does all prediction
module tb_fractional_decimating_fir_resampler_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS        = frdr_pkg::TAPS;
    localparam int SAMPLE_BITS = frdr_pkg::SAMPLE_BITS;
    localparam int RATIO_W     = frdr_pkg::RATIO_W;
    localparam int CFG_IDX_W   = frdr_pkg::CFG_IDX_W;

    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 400;

    // no register sits behind this index
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    // alone on the center tap this lands exactly halfway between two output codes
    localparam logic signed [SAMPLE_BITS-1:0] TIE_IMPULSE = 16'sd1024;

    // shapes of random input runs
    typedef enum int {
        WIDE,
        EXTREME,
        QUIET,
        SINC_MATCH,
        IMPULSE
    } word_kind_t;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index  = frdr_pkg::REG_CAPTURE_ENABLE;
    logic [RATIO_W-1:0]            cfg_data   = '0;
    logic                          in_valid   = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] in_sample  = '0;
    logic                          out_valid;
    logic                          out_stall  = 1'b0;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    int   send_idle = 27;
    int   recv_idle = 51;
    logic long_hold = 1'b0;
    event long_hold_start;
    int   mismatches;
    int   outstanding;

    fractional_decimating_fir_resampler_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_sample  (in_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample)
    );

    frdr_output_checker output_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_sample   (in_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_sample  (out_sample),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, plus one long hold-off
    always @(posedge clk)
        out_stall <= long_hold || ($urandom_range(99) < recv_idle);

    initial
    begin
        @(long_hold_start);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // offer one word, return once it is taken and in_stall is low again
    task automatic send_word(input logic signed [SAMPLE_BITS-1:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [RATIO_W-1:0]   value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every predicted word has come out and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // full-scale word with the sign of the tap it will meet, or the opposite sign when negated
    function automatic logic signed [SAMPLE_BITS-1:0] sign_matched(input int tap,
                                                                  input bit negate);
        if ((frdr_pkg::TAP_COEF[tap] < 0) != negate)
            return SAMPLE_MIN;
        return SAMPLE_MAX;
    endfunction

    task automatic send_random(input int count);
        int                            left;
        int                            run;
        word_kind_t                    kind;
        bit                            flip;
        logic signed [SAMPLE_BITS-1:0] value;
        left = count;
        while (left > 0)
        begin
            kind = word_kind_t'($urandom_range(4));
            run  = (kind == SINC_MATCH) ? 2 * TAPS : int'($urandom_range(30, 5));
            if (run > left)
                run = left;
            flip = 1'($urandom_range(1));
            for (int j = 0; j < run; j++)
            begin
                case (kind)
                    WIDE:
                        value = SAMPLE_BITS'($urandom);
                    EXTREME:
                        case ($urandom_range(3))
                            0:       value = SAMPLE_MAX;
                            1:       value = SAMPLE_MIN;
                            2:       value = '0;
                            default: value = '1;
                        endcase
                    QUIET:
                        value = SAMPLE_BITS'(int'($urandom_range(64)) - 32);
                    SINC_MATCH:
                        value = sign_matched(j % TAPS, flip);
                    default:
                        if ($urandom_range(7) == 0)
                            value = $urandom_range(1) ? TIE_IMPULSE : -TIE_IMPULSE;
                        else
                            value = '0;
                endcase
                send_word(value);
            end
            left -= run;
        end
    endtask

    task automatic run_phase(input logic [RATIO_W-1:0] ratio, input int count);
        wait_idle();
        write_reg(frdr_pkg::REG_RATE_RATIO, ratio);
        send_random(count);
    endtask

    // disable with junk in the upper bits, feed dropped words, enable again
    task automatic restart_stream();
        logic [RATIO_W-1:0] junk;
        wait_idle();
        junk = RATIO_W'($urandom);
        write_reg(frdr_pkg::REG_CAPTURE_ENABLE, {junk[RATIO_W-1:1], 1'b0});
        repeat (3) send_word(SAMPLE_BITS'($urandom));
        wait_idle();
        junk = RATIO_W'($urandom);
        write_reg(frdr_pkg::REG_CAPTURE_ENABLE, {junk[RATIO_W-1:1], 1'b1});
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // capture off after reset: words are dropped
        repeat (3) send_word(SAMPLE_BITS'($urandom));
        wait_idle();
        write_reg(frdr_pkg::REG_RATE_RATIO, frdr_pkg::RATIO_MIN);
        write_reg(frdr_pkg::REG_CAPTURE_ENABLE, 21'd1);

        // window matched to the tap signs clips high, then one tie impulse of each sign
        for (int t = 0; t < TAPS; t++)
            send_word(sign_matched(t, 1'b0));
        send_word(-TIE_IMPULSE);
        send_word(TIE_IMPULSE);

        // sender idles less than the receiver
        run_phase(frdr_pkg::RATIO_RESET, 50);
        run_phase(frdr_pkg::RATIO_MAX, 50);
        restart_stream();
        run_phase(21'd98304, 50);

        // receiver idles less than the sender; out-of-range ratios get clamped
        wait_idle();
        send_idle = 51;
        recv_idle <= 27;
        run_phase(21'd0, 50);
        run_phase(21'd65535, 40);
        run_phase(21'd1048577, 40);
        wait_idle();
        write_reg(REG_SPARE, RATIO_W'($urandom));
        run_phase(21'h1FFFFF, 40);

        // no idling; one long output hold-off fills the block
        wait_idle();
        send_idle = 0;
        recv_idle <= 0;
        run_phase(RATIO_W'($urandom_range(frdr_pkg::RATIO_MAX, frdr_pkg::RATIO_MIN)), 50);
        wait_idle();
        write_reg(frdr_pkg::REG_RATE_RATIO,
                  RATIO_W'($urandom_range(21'd200000, frdr_pkg::RATIO_MIN)));
        -> long_hold_start;
        send_random(60);
        restart_stream();
        run_phase(frdr_pkg::RATIO_MIN + 21'd1, 60);
        run_phase(RATIO_W'($urandom_range(frdr_pkg::RATIO_MAX, frdr_pkg::RATIO_MIN)), 60);

        wait_idle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
